// ----- hw/rtl/u8js_pkg.sv -----
// Shared types, constants and helper functions for the UTF-8 repair and JSON escape block.
`timescale 1ns / 1ps

package u8js_pkg;

  localparam int CmdqDepth = 2;
  localparam int CmdqPtrW  = 1;
  localparam int CmdqCntW  = 2;

  localparam int BodyMax  = 6;
  localparam int BodyLenW = 3;
  localparam int FffdCntW = 3;

  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChLowerU = 8'h75;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChSpace  = 8'h20;

  localparam logic [7:0] LeadLo  = 8'hC2;
  localparam logic [7:0] Lead3Lo = 8'hE0;
  localparam logic [7:0] Lead4Lo = 8'hF0;
  localparam logic [7:0] LeadHi  = 8'hF5;

  localparam logic [20:0] CpMin2  = 21'h00080;
  localparam logic [20:0] CpMin3  = 21'h00800;
  localparam logic [20:0] CpMin4  = 21'h10000;
  localparam logic [20:0] CpMax   = 21'h10FFFF;
  localparam logic [20:0] CpSurLo = 21'h0D800;
  localparam logic [20:0] CpSurHi = 21'h0DFFF;

  typedef enum logic [1:0] {
    PhOpen,
    PhFffd,
    PhBody,
    PhClose
  } phase_e;

  typedef struct packed {
    logic                        open;
    logic [FffdCntW-1:0]         fffd_cnt;
    logic [BodyLenW-1:0]         body_len;
    logic [BodyMax-1:0][7:0]     body;
    logic                        close;
  } cmd_t;

  function automatic logic [7:0] fffd_byte(input logic [1:0] k);
    logic [7:0] b;
    unique case (k)
      2'd0:    b = 8'hEF;
      2'd1:    b = 8'hBF;
      2'd2:    b = 8'hBD;
      default: b = 8'hBD;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    logic [7:0] b;
    if (n < 4'd10) begin
      b = {4'h3, n};
    end else begin
      b = 8'h57 + {4'h0, n};
    end
    return b;
  endfunction

  // Short escape letter, zero when the byte has none
  function automatic logic [7:0] esc_char(input logic [7:0] c);
    logic [7:0] e;
    unique case (c)
      8'h22:   e = 8'h22;
      8'h5C:   e = 8'h5C;
      8'h08:   e = 8'h62;
      8'h0C:   e = 8'h66;
      8'h0A:   e = 8'h6E;
      8'h0D:   e = 8'h72;
      8'h09:   e = 8'h74;
      default: e = 8'h00;
    endcase
    return e;
  endfunction

endpackage

// ----- hw/rtl/utf8_repair_json_string_escape.sv -----
// Top level: UTF-8 repair and JSON string escaping, one byte in and byte-wide results out.
//
//   channel  | direction | handshake                  | fields
//   items    | in        | push_i, full_o             | in_byte_i, string_start_i,
//            |           |                            | string_end_i, no_byte_i
//   results  | out       | pop_i, empty_o             | out_byte_o, last_of_run_o,
//            |           |                            | closing_quote_o
//
// One item is accepted per cycle while the two-entry command queue has room.
// The back-end sequencer emits one result byte per cycle while the result register is
// empty or being popped; an item that causes any bytes causes from 1 up to 16.
// The first result of an item passes through the command queue and then the result register.
// Reset clears the pending sequence and the command queue, and empties the result register.
// A held result keeps the sequencer stalled; the front end runs on until the queue fills.
`timescale 1ns / 1ps

module utf8_repair_json_string_escape (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  output logic        full_o,
  input  logic [7:0]  in_byte_i,
  input  logic        string_start_i,
  input  logic        string_end_i,
  input  logic        no_byte_i,
  input  logic        pop_i,
  output logic        empty_o,
  output logic [7:0]  out_byte_o,
  output logic        last_of_run_o,
  output logic        closing_quote_o
);

  logic              accept;
  logic              cmd_we;
  logic              cmd_valid;
  logic              cmd_pop;
  u8js_pkg::cmd_t    cmd_wr;
  u8js_pkg::cmd_t    cmd_rd;

  assign accept = push_i && !full_o;

  u8js_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .in_byte_i      (in_byte_i),
    .string_start_i (string_start_i),
    .string_end_i   (string_end_i),
    .no_byte_i      (no_byte_i),
    .cmd_o          (cmd_wr),
    .cmd_we_o       (cmd_we)
  );

  u8js_cmdq u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (cmd_we),
    .wdata_i (cmd_wr),
    .full_o  (full_o),
    .rd_i    (cmd_pop),
    .rdata_o (cmd_rd),
    .valid_o (cmd_valid)
  );

  u8js_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd_rd),
    .cmd_valid_i     (cmd_valid),
    .cmd_pop_o       (cmd_pop),
    .pop_i           (pop_i),
    .empty_o         (empty_o),
    .out_byte_o      (out_byte_o),
    .last_of_run_o   (last_of_run_o),
    .closing_quote_o (closing_quote_o)
  );

endmodule

// ----- hw/rtl/u8js_front.sv -----
// Front end: tracks the pending UTF-8 sequence and turns each item that yields output into a command.
`timescale 1ns / 1ps

module u8js_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        in_byte_i,
  input  logic              string_start_i,
  input  logic              string_end_i,
  input  logic              no_byte_i,
  output u8js_pkg::cmd_t    cmd_o,
  output logic              cmd_we_o
);

  logic [1:0]  hc_q, hc_d;
  logic [1:0]  need_q, need_d;
  logic [20:0] acc_q, acc_d;
  logic [7:0]  held_q [3];
  logic [7:0]  held_d [3];

  logic [1:0]                     hc_e;
  logic [1:0]                     need_e;
  logic [20:0]                    acc_e;
  logic [20:0]                    acc_c;
  logic [u8js_pkg::FffdCntW-1:0]  fffd;
  logic [u8js_pkg::BodyLenW-1:0]  len;
  logic                           lead;
  logic                           ok;
  logic [7:0]                     esc;
  u8js_pkg::cmd_t                 cmd;

  always_comb begin
    hc_e   = string_start_i ? 2'd0 : hc_q;
    need_e = string_start_i ? 2'd0 : need_q;
    acc_e  = string_start_i ? 21'd0 : acc_q;
    hc_d   = hc_e;
    need_d = need_e;
    acc_d  = acc_e;
    held_d = held_q;
    cmd    = '0;
    cmd.open = string_start_i;
    fffd   = '0;
    lead   = 1'b0;
    ok     = 1'b1;
    esc    = 8'h00;
    acc_c  = {acc_e[14:0], in_byte_i[5:0]};
    len    = {1'b0, hc_e} + 3'd1;

    if (!no_byte_i) begin
      if (need_e == 2'd0) begin
        lead = 1'b1;
      end else if (in_byte_i[7:6] != 2'b10) begin
        fffd   = {1'b0, hc_e};
        hc_d   = 2'd0;
        need_d = 2'd0;
        acc_d  = 21'd0;
        lead   = 1'b1;
      end else if (need_e != 2'd1) begin
        held_d[hc_e] = in_byte_i;
        hc_d   = hc_e + 2'd1;
        need_d = need_e - 2'd1;
        acc_d  = acc_c;
      end else begin
        if (len == 3'd2 && acc_c < u8js_pkg::CpMin2) ok = 1'b0;
        if (len == 3'd3 && acc_c < u8js_pkg::CpMin3) ok = 1'b0;
        if (len == 3'd4 && acc_c < u8js_pkg::CpMin4) ok = 1'b0;
        if (acc_c > u8js_pkg::CpMax) ok = 1'b0;
        if (acc_c >= u8js_pkg::CpSurLo && acc_c <= u8js_pkg::CpSurHi) ok = 1'b0;
        if (ok) begin
          for (int k = 0; k < 3; k++) begin
            cmd.body[k] = (k < int'(hc_e)) ? held_q[k] : in_byte_i;
          end
          cmd.body[3]  = in_byte_i;
          cmd.body_len = len;
        end else begin
          fffd = len;
        end
        hc_d   = 2'd0;
        need_d = 2'd0;
        acc_d  = 21'd0;
      end

      if (lead) begin
        esc = u8js_pkg::esc_char(in_byte_i);
        if (!in_byte_i[7]) begin
          if (esc != 8'h00) begin
            cmd.body[0]  = u8js_pkg::ChBslash;
            cmd.body[1]  = esc;
            cmd.body_len = 3'd2;
          end else if (in_byte_i < u8js_pkg::ChSpace) begin
            cmd.body[0]  = u8js_pkg::ChBslash;
            cmd.body[1]  = u8js_pkg::ChLowerU;
            cmd.body[2]  = u8js_pkg::ChZero;
            cmd.body[3]  = u8js_pkg::ChZero;
            cmd.body[4]  = u8js_pkg::hex_digit(in_byte_i[7:4]);
            cmd.body[5]  = u8js_pkg::hex_digit(in_byte_i[3:0]);
            cmd.body_len = 3'd6;
          end else begin
            cmd.body[0]  = in_byte_i;
            cmd.body_len = 3'd1;
          end
        end else if (in_byte_i < u8js_pkg::LeadLo || in_byte_i >= u8js_pkg::LeadHi) begin
          fffd = fffd + 3'd1;
        end else begin
          held_d[0] = in_byte_i;
          hc_d      = 2'd1;
          if (in_byte_i < u8js_pkg::Lead3Lo) begin
            need_d = 2'd1;
            acc_d  = {16'd0, in_byte_i[4:0]};
          end else if (in_byte_i < u8js_pkg::Lead4Lo) begin
            need_d = 2'd2;
            acc_d  = {17'd0, in_byte_i[3:0]};
          end else begin
            need_d = 2'd3;
            acc_d  = {18'd0, in_byte_i[2:0]};
          end
        end
      end
    end

    if (string_end_i) begin
      fffd      = fffd + {1'b0, hc_d};
      hc_d      = 2'd0;
      need_d    = 2'd0;
      acc_d     = 21'd0;
      cmd.close = 1'b1;
    end

    cmd.fffd_cnt = fffd;
  end

  assign cmd_o    = cmd;
  assign cmd_we_o = accept_i &&
                    (cmd.open || cmd.close || (fffd != '0) || (cmd.body_len != '0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hc_q   <= 2'd0;
      need_q <= 2'd0;
      acc_q  <= 21'd0;
    end else if (accept_i) begin
      hc_q   <= hc_d;
      need_q <= need_d;
      acc_q  <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      held_q <= held_d;
    end
  end

endmodule

// ----- hw/rtl/u8js_cmdq.sv -----
// Two-entry command queue between the front end and the byte sequencer.
`timescale 1ns / 1ps

module u8js_cmdq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_i,
  input  u8js_pkg::cmd_t    wdata_i,
  output logic              full_o,
  input  logic              rd_i,
  output u8js_pkg::cmd_t    rdata_o,
  output logic              valid_o
);

  u8js_pkg::cmd_t                   mem_q [u8js_pkg::CmdqDepth];
  logic [u8js_pkg::CmdqPtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [u8js_pkg::CmdqCntW-1:0]    cnt_q, cnt_d;

  assign full_o  = (cnt_q == u8js_pkg::CmdqCntW'(u8js_pkg::CmdqDepth));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign cnt_d   = cnt_q + u8js_pkg::CmdqCntW'(wr_i) - u8js_pkg::CmdqCntW'(rd_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_i) begin
        wr_ptr_q <= wr_ptr_q + u8js_pkg::CmdqPtrW'(1);
      end
      if (rd_i) begin
        rd_ptr_q <= rd_ptr_q + u8js_pkg::CmdqPtrW'(1);
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ----- hw/rtl/u8js_back.sv -----
// Back end: walks each command and emits its bytes one per cycle into the result register while it is free or popped.
`timescale 1ns / 1ps

module u8js_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  u8js_pkg::cmd_t    cmd_i,
  input  logic              cmd_valid_i,
  output logic              cmd_pop_o,
  input  logic              pop_i,
  output logic              empty_o,
  output logic [7:0]        out_byte_o,
  output logic              last_of_run_o,
  output logic              closing_quote_o
);

  u8js_pkg::phase_e                phase_q, phase_d, eph;
  logic [u8js_pkg::FffdCntW-1:0]   rep_q, rep_d;
  logic [1:0]                      sub_q, sub_d;
  logic [u8js_pkg::BodyLenW-1:0]   idx_q, idx_d;

  logic        out_valid_q;
  logic [7:0]  out_byte_q;
  logic        out_last_q;
  logic        out_close_q;

  logic [7:0]  byte_c;
  logic        done;
  logic        more;
  logic        last;
  logic        is_close;
  logic        adv;

  always_comb begin
    eph = phase_q;
    if (eph == u8js_pkg::PhOpen && !cmd_i.open) eph = u8js_pkg::PhFffd;
    if (eph == u8js_pkg::PhFffd && cmd_i.fffd_cnt == '0) eph = u8js_pkg::PhBody;
    if (eph == u8js_pkg::PhBody && cmd_i.body_len == '0) eph = u8js_pkg::PhClose;

    byte_c   = u8js_pkg::ChQuote;
    done     = 1'b1;
    more     = 1'b0;
    is_close = 1'b0;
    unique case (eph)
      u8js_pkg::PhOpen: begin
        more = (cmd_i.fffd_cnt != '0) || (cmd_i.body_len != '0) || cmd_i.close;
      end
      u8js_pkg::PhFffd: begin
        byte_c = u8js_pkg::fffd_byte(sub_q);
        done   = (sub_q == 2'd2) && (rep_q == cmd_i.fffd_cnt - 3'd1);
        more   = (cmd_i.body_len != '0) || cmd_i.close;
      end
      u8js_pkg::PhBody: begin
        byte_c = cmd_i.body[idx_q];
        done   = (idx_q == cmd_i.body_len - 3'd1);
        more   = cmd_i.close;
      end
      u8js_pkg::PhClose: begin
        is_close = 1'b1;
      end
      default: begin
        is_close = 1'b0;
      end
    endcase
    last = done && !more;
    adv  = cmd_valid_i && (!out_valid_q || pop_i);

    phase_d = phase_q;
    rep_d   = rep_q;
    sub_d   = sub_q;
    idx_d   = idx_q;
    if (adv) begin
      if (last) begin
        phase_d = u8js_pkg::PhOpen;
        rep_d   = '0;
        sub_d   = '0;
        idx_d   = '0;
      end else if (done) begin
        rep_d = '0;
        sub_d = '0;
        idx_d = '0;
        unique case (eph)
          u8js_pkg::PhOpen: phase_d = u8js_pkg::PhFffd;
          u8js_pkg::PhFffd: phase_d = u8js_pkg::PhBody;
          default:          phase_d = u8js_pkg::PhClose;
        endcase
      end else if (eph == u8js_pkg::PhFffd) begin
        if (sub_q == 2'd2) begin
          sub_d = 2'd0;
          rep_d = rep_q + 3'd1;
        end else begin
          sub_d = sub_q + 2'd1;
        end
      end else begin
        idx_d = idx_q + 3'd1;
      end
    end
  end

  assign cmd_pop_o = adv && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= u8js_pkg::PhOpen;
      rep_q       <= '0;
      sub_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      rep_q   <= rep_d;
      sub_q   <= sub_d;
      idx_q   <= idx_d;
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_byte_q  <= byte_c;
      out_last_q  <= last;
      out_close_q <= is_close;
    end
  end

  assign empty_o         = !out_valid_q;
  assign out_byte_o      = out_byte_q;
  assign last_of_run_o   = out_last_q;
  assign closing_quote_o = out_close_q;

endmodule

// ----- hw/rtl/u8js_checker.sv -----
// Port-level checks on the result channel, bound to the top level.
`timescale 1ns / 1ps

module u8js_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        pop_i,
  input  logic        empty_o,
  input  logic [7:0]  out_byte_o,
  input  logic        last_of_run_o,
  input  logic        closing_quote_o
);

  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !pop_i) |=> (!empty_o && $stable(out_byte_o) &&
                              $stable(last_of_run_o) && $stable(closing_quote_o)))
    else $error("waiting item changed before pop");

  a_close_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && closing_quote_o) |-> (last_of_run_o && out_byte_o == 8'h22))
    else $error("closing quote not a final quote byte");

  a_no_raw_control: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> (out_byte_o >= 8'h20))
    else $error("unescaped control byte on output");

  a_no_bad_utf8: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> (out_byte_o != 8'hC0 && out_byte_o != 8'hC1 && out_byte_o < 8'hF5))
    else $error("byte that never occurs in valid UTF-8 on output");

endmodule

bind utf8_repair_json_string_escape u8js_checker u_checker (.*);
